>>> sv/rsg_pkg.sv
// Shared constants and types for the RGB Sobel gradient block.
`timescale 1ns / 1ps

package rsg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Position counters and clamped frame size.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EH_W  = $clog2(MAX_HEIGHT + 1);

    // Configuration port.
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam logic REQ_DRAIN = 1'b1;

    // Datapath widths.
    localparam int LUMA_W = 16;
    localparam int SUM_W  = LUMA_W + 2;
    localparam int GRAD_W = SUM_W + 1;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int RAD_W  = 2 * (SUM_W + 1);
    localparam int MAG_W  = RAD_W / 2;
    localparam int REM_W  = MAG_W + 2;
    localparam int REMX_W = REM_W + 2;
    localparam int SQRT_STAGES = MAG_W;
    localparam int MAG_MAX = 369280;

    // Output buffer.
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
    } line_rd_t;

    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              last;
        logic              left_ok;
        logic              right_ok;
        logic              top_ok;
        logic              bot_ok;
        logic [COL_W-1:0]  col;
        logic [LUMA_W-1:0] luma;
    } pix_ctl_t;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [GRAD_W-1:0] sx;
        logic signed [GRAD_W-1:0] sy;
    } grad_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [MAG_W-1:0] mag;
    } mag_t;

endpackage

>>> sv/rsg_ctrl.sv
// Frame position tracking, configuration registers and luma conversion.
`timescale 1ns / 1ps

module rsg_ctrl
    import rsg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [7:0]            s_red,
    input  logic [7:0]            s_green,
    input  logic [7:0]            s_blue,
    output line_rd_t              line_rd,
    output pix_ctl_t              pix,
    output logic                  reserve
);

    localparam logic [7:0] K_RED   = 8'd54;
    localparam logic [7:0] K_GREEN = 8'd183;
    localparam logic [7:0] K_BLUE  = 8'd19;

    function automatic logic [EW_W-1:0] clamp_width(input logic [FW_W-1:0] v);
        if (v == '0) begin
            clamp_width = EW_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            clamp_width = EW_W'(MAX_WIDTH);
        end else begin
            clamp_width = EW_W'(v);
        end
    endfunction

    function automatic logic [EH_W-1:0] clamp_height(input logic [FH_W-1:0] v);
        if (v == '0) begin
            clamp_height = EH_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            clamp_height = EH_W'(MAX_HEIGHT);
        end else begin
            clamp_height = EH_W'(v);
        end
    endfunction

    function automatic logic [LUMA_W-1:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        luma_of = LUMA_W'(LUMA_W'(r) * LUMA_W'(K_RED) + LUMA_W'(g) * LUMA_W'(K_GREEN)
                          + LUMA_W'(b) * LUMA_W'(K_BLUE));
    endfunction

    logic [EW_W-1:0]  eff_w_reg;
    logic [EH_W-1:0]  eff_h_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pix_ctl_t         pix_reg, pix_next;
    logic [ROW_W-1:0] h_ext;
    logic             accept, done, act, first_col, main_case, wrap;

    always_comb begin
        h_ext     = ROW_W'(eff_h_reg);
        accept    = s_valid && s_ready;
        done      = row_reg >= h_ext;
        // drop a drain request while pixels of the frame are still due
        act       = accept && (done || (s_req_type != REQ_DRAIN));
        first_col = (col_reg == '0) && (row_reg >= ROW_W'(2));
        main_case = (col_reg != '0) && (row_reg != '0);
        wrap      = (EW_W'(col_reg) + EW_W'(1)) >= eff_w_reg;

        pix_next          = '0;
        pix_next.valid    = act;
        pix_next.emit     = first_col || main_case;
        pix_next.col      = col_reg;
        pix_next.luma     = done ? '0 : luma_of(s_red, s_green, s_blue);
        pix_next.right_ok = main_case;
        if (main_case) begin
            pix_next.left_ok = col_reg >= COL_W'(2);
            pix_next.top_ok  = row_reg >= ROW_W'(2);
            pix_next.bot_ok  = row_reg < h_ext;
            pix_next.last    = 1'b0;
        end else begin
            // column zero: the centre is the last pixel of the row two up
            pix_next.left_ok = eff_w_reg > EW_W'(1);
            pix_next.top_ok  = row_reg >= ROW_W'(3);
            pix_next.bot_ok  = row_reg <= h_ext;
            pix_next.last    = first_col && (row_reg == h_ext + ROW_W'(1));
        end

        col_next = col_reg;
        row_next = row_reg;
        if (act) begin
            if (pix_next.last) begin
                col_next = '0;
                row_next = '0;
            end else if (wrap) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= clamp_width(FW_W'(FRAME_WIDTH_RST));
            eff_h_reg <= clamp_height(FH_W'(FRAME_HEIGHT_RST));
            col_reg   <= '0;
            row_reg   <= '0;
            pix_reg   <= '0;
        end else begin
            pix_reg <= pix_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        eff_w_reg <= clamp_width(cfg_wdata[FW_W-1:0]);
                    end
                    REG_FRAME_HEIGHT: begin
                        eff_h_reg <= clamp_height(cfg_wdata[FH_W-1:0]);
                    end
                    default: begin
                    end
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end else begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    assign line_rd.en   = act;
    assign line_rd.addr = col_reg;
    assign pix          = pix_reg;
    assign reserve      = act && pix_next.emit;

endmodule

>>> sv/rsg_window.sv
// Line stores, 3x3 luma window and Sobel sums.
`timescale 1ns / 1ps

module rsg_window
    import rsg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  line_rd_t line_rd,
    input  pix_ctl_t pix,
    output grad_t    grad
);

    logic [LUMA_W-1:0] upper_mem  [0:MAX_WIDTH-1];
    logic [LUMA_W-1:0] middle_mem [0:MAX_WIDTH-1];
    logic [LUMA_W-1:0] upper_rd_reg, middle_rd_reg;
    logic              byp_reg;
    logic [LUMA_W-1:0] byp_top_reg, byp_mid_reg;
    logic [2:0][LUMA_W-1:0] lcol_reg, ccol_reg;
    logic [2:0][LUMA_W-1:0] rcol, l, c, r;
    logic [2:0]        row_ok;
    logic [LUMA_W-1:0] top, mid;
    logic [SUM_W-1:0]  lx, rx, uy, dy;
    grad_t             grad_reg, grad_next;

    always_ff @(posedge aclk) begin
        if (line_rd.en) begin
            upper_rd_reg  <= upper_mem[line_rd.addr];
            middle_rd_reg <= middle_mem[line_rd.addr];
        end
        if (pix.valid) begin
            upper_mem[pix.col]  <= mid;
            middle_mem[pix.col] <= pix.luma;
        end
    end

    // forward the entry being written when the next request reads the same column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= line_rd.en && pix.valid && (line_rd.addr == pix.col);
        end
    end

    always_ff @(posedge aclk) begin
        byp_top_reg <= mid;
        byp_mid_reg <= pix.luma;
        if (pix.valid) begin
            lcol_reg <= ccol_reg;
            ccol_reg <= rcol;
        end
    end

    always_comb begin
        top     = byp_reg ? byp_top_reg : upper_rd_reg;
        mid     = byp_reg ? byp_mid_reg : middle_rd_reg;
        rcol[0] = top;
        rcol[1] = mid;
        rcol[2] = pix.luma;
        row_ok  = {pix.bot_ok, 1'b1, pix.top_ok};
        for (int i = 0; i < 3; i++) begin
            l[i] = (row_ok[i] && pix.left_ok)  ? lcol_reg[i] : '0;
            c[i] = row_ok[i] ? ccol_reg[i] : '0;
            r[i] = (row_ok[i] && pix.right_ok) ? rcol[i] : '0;
        end
        lx = SUM_W'(l[0]) + (SUM_W'(l[1]) << 1) + SUM_W'(l[2]);
        rx = SUM_W'(r[0]) + (SUM_W'(r[1]) << 1) + SUM_W'(r[2]);
        uy = SUM_W'(l[0]) + (SUM_W'(c[0]) << 1) + SUM_W'(r[0]);
        dy = SUM_W'(l[2]) + (SUM_W'(c[2]) << 1) + SUM_W'(r[2]);

        grad_next.valid = pix.valid && pix.emit;
        grad_next.last  = pix.last;
        grad_next.sx    = $signed({1'b0, lx}) - $signed({1'b0, rx});
        grad_next.sy    = $signed({1'b0, uy}) - $signed({1'b0, dy});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grad_reg <= '0;
        end else begin
            grad_reg <= grad_next;
        end
    end

    assign grad = grad_reg;

endmodule

>>> sv/rsg_sqrt.sv
// Squares, energy sum and pipelined floor square root.
`timescale 1ns / 1ps

module rsg_sqrt
    import rsg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  grad_t grad,
    output mag_t  mag
);

    logic [SUM_W-1:0]  ax, ay;
    logic [SQ_W-1:0]   sq_x, sq_y;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic              sq_vld_reg, sq_last_reg;
    logic [RAD_W-1:0]  rad_reg  [0:SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [0:SQRT_STAGES];
    logic [MAG_W-1:0]  root_reg [0:SQRT_STAGES];
    logic              vld_reg  [0:SQRT_STAGES];
    logic              lst_reg  [0:SQRT_STAGES];

    always_comb begin
        ax   = grad.sx[GRAD_W-1] ? SUM_W'(-grad.sx) : SUM_W'(grad.sx);
        ay   = grad.sy[GRAD_W-1] ? SUM_W'(-grad.sy) : SUM_W'(grad.sy);
        sq_x = SQ_W'(ax) * SQ_W'(ax);
        sq_y = SQ_W'(ay) * SQ_W'(ay);
    end

    always_ff @(posedge aclk) begin
        sqx_reg      <= sq_x;
        sqy_reg      <= sq_y;
        sq_last_reg  <= grad.last;
        rad_reg[0]   <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
        rem_reg[0]   <= '0;
        root_reg[0]  <= '0;
        lst_reg[0]   <= sq_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else begin
            sq_vld_reg <= grad.valid;
            vld_reg[0] <= sq_vld_reg;
        end
    end

    // one result bit per stage, most significant first
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REMX_W-1:0] rem_sh;
        logic [REMX_W-1:0] trial;
        logic              fits;

        assign rem_sh = {rem_reg[k], rad_reg[k][RAD_W-1 -: 2]};
        assign trial  = REMX_W'({root_reg[k], 2'b01});
        assign fits   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            rad_reg[k+1]  <= rad_reg[k] << 2;
            rem_reg[k+1]  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg[k+1] <= {root_reg[k][MAG_W-2:0], fits};
            lst_reg[k+1]  <= lst_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    assign mag.valid = vld_reg[SQRT_STAGES];
    assign mag.last  = lst_reg[SQRT_STAGES];
    assign mag.mag   = root_reg[SQRT_STAGES];

endmodule

>>> sv/rsg_fifo.sv
// Output buffer with slot reservation at request acceptance.
`timescale 1ns / 1ps

module rsg_fifo
    import rsg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             reserve,
    input  mag_t             wr,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [MAG_W-1:0] out_mag,
    output logic             out_last
);

    logic [MAG_W:0]       mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, occ_reg;
    logic                 pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign {out_last, out_mag} = mem[rd_ptr_reg];
    // slots held by results still in the pipeline count as taken
    assign space     = occ_reg < CNT_W'(FIFO_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            mem[wr_ptr_reg] <= {wr.last, wr.mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            occ_reg    <= '0;
        end else begin
            if (wr.valid) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + CNT_W'(wr.valid) - CNT_W'(pop);
            occ_reg   <= occ_reg + CNT_W'(reserve) - CNT_W'(pop);
        end
    end

endmodule

>>> sv/rgb_sobel_gradient_top.sv
// Output: a result is valid once the request that completes its window has passed the pipeline,
// and that request comes frame_width+1 requests after the pixel the result belongs to.
// Throughput: one request per cycle; s_ready falls only when the 32-entry output
// buffer is fully claimed by results waiting or still in the 23-stage pipeline.
// Reset: clears position, output buffer and valid bits; width 640, height 480.
// Line stores are not cleared; unwritten entries are always masked at frame edges.
`timescale 1ns / 1ps

module rgb_sobel_gradient_top
    import rsg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [7:0]            s_red,
    input  logic [7:0]            s_green,
    input  logic [7:0]            s_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MAG_W-1:0]      m_gradient_mag,
    output logic                  m_last_of_frame
);

    line_rd_t line_rd;
    pix_ctl_t pix;
    grad_t    grad;
    mag_t     mag;
    logic     reserve;

    rsg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_red      (s_red),
        .s_green    (s_green),
        .s_blue     (s_blue),
        .line_rd    (line_rd),
        .pix        (pix),
        .reserve    (reserve)
    );

    rsg_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .line_rd (line_rd),
        .pix     (pix),
        .grad    (grad)
    );

    rsg_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .grad    (grad),
        .mag     (mag)
    );

    rsg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .reserve   (reserve),
        .wr        (mag),
        .space     (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_mag   (m_gradient_mag),
        .out_last  (m_last_of_frame)
    );

endmodule

>>> sv/rsg_checker.sv
// Port-level checks for the RGB Sobel gradient block and their binding.
`timescale 1ns / 1ps

module rsg_checker
    import rsg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [MAG_W-1:0]      m_gradient_mag,
    input logic                  m_last_of_frame
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gradient_mag)
                                && $stable(m_last_of_frame))
        else $error("stalled result changed");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_gradient_mag) <= MAG_MAX)
        else $error("gradient magnitude out of range");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // checks that a full buffer claim comes with results waiting at the output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("request blocked with no result waiting");

endmodule

bind rgb_sobel_gradient_top rsg_checker u_rsg_checker (.*);

>>> test/tb_rgb_sobel_gradient_top.sv
// Testbench for the RGB Sobel gradient block: predicts every gradient and checks results in order.
`timescale 1ns / 1ps

module tb_rgb_sobel_gradient_top;
    import rsg_pkg::*;

    localparam logic REQ_PIXEL     = ~REQ_DRAIN;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   RANDOM_ITEMS  = 560;
    localparam int   MAX_PRINTS    = 40;

    // Holds the frame position, line stores and window of the block and
    // turns each accepted request into the gradient it will produce.
    class gradient_scoreboard;
        typedef struct {
            logic [MAG_W-1:0] mag;
            logic             last;
        } grad_result_t;

        int unsigned       width_reg;
        int unsigned       height_reg;
        logic [LUMA_W-1:0] line_upper [MAX_WIDTH];
        logic [LUMA_W-1:0] line_middle [MAX_WIDTH];
        logic [LUMA_W-1:0] win [9];
        int unsigned       col_pos;
        int unsigned       row_pos;
        int unsigned       emitted;
        grad_result_t      expected_grads [$];
        int                errors;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (line_upper[i]) line_upper[i] = '0;
            foreach (line_middle[i]) line_middle[i] = '0;
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = 32'(data[FW_W-1:0]);
                REG_FRAME_HEIGHT: height_reg = 32'(data[FH_W-1:0]);
                default: return;
            endcase
            restart_frame();
        endfunction

        function int unsigned eff_width();
            if (width_reg < 1) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < 1) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned res;
            longint unsigned trial;
            res = 0;
            for (int b = MAG_W; b >= 0; b--) begin
                trial = res | (64'd1 << b);
                if (trial * trial <= v) res = trial;
            end
            return res;
        endfunction

        // Window columns start at base: left, centre, and right when present.
        function logic [MAG_W-1:0] sobel_mag(int base, bit has_right, bit left_ok,
                                             bit top_ok, bit bot_ok);
            longint lv [3];
            longint cv [3];
            longint rv [3];
            longint sx;
            longint sy;
            bit     row_ok;
            for (int i = 0; i < 3; i++) begin
                row_ok = (i == 0) ? top_ok : ((i == 2) ? bot_ok : 1'b1);
                lv[i] = (row_ok && left_ok) ? longint'(win[base + i]) : 0;
                cv[i] = row_ok ? longint'(win[base + 3 + i]) : 0;
                rv[i] = 0;
                if (row_ok && has_right) rv[i] = longint'(win[base + 6 + i]);
            end
            sx = (lv[0] + 2 * lv[1] + lv[2]) - (rv[0] + 2 * rv[1] + rv[2]);
            sy = (lv[0] + 2 * cv[0] + rv[0]) - (lv[2] + 2 * cv[2] + rv[2]);
            return MAG_W'(floor_root(longint'(sx * sx + sy * sy)));
        endfunction

        function void note_request(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned       w;
            int unsigned       h;
            int unsigned       luma;
            logic [LUMA_W-1:0] top;
            logic [LUMA_W-1:0] mid;
            bit                have;
            grad_result_t      res;
            w = eff_width();
            h = eff_height();
            // Drop a drain tick while the frame still wants pixels.
            if (row_pos < h && req == REQ_DRAIN) return;
            luma = 0;
            if (row_pos < h) luma = 54 * r + 183 * g + 19 * b;

            top = line_upper[col_pos];
            mid = line_middle[col_pos];
            line_upper[col_pos]  = mid;
            line_middle[col_pos] = luma[LUMA_W-1:0];

            have = 0;
            res.mag = '0;
            // Row start: finish the last pixel of the row two rows up.
            if (col_pos == 0 && row_pos >= 2) begin
                res.mag = sobel_mag(3, 1'b0, w > 1, row_pos >= 3, row_pos - 1 < h);
                have = 1;
            end

            for (int i = 0; i < 6; i++) win[i] = win[i + 3];
            win[6] = top;
            win[7] = mid;
            win[8] = luma[LUMA_W-1:0];

            if (col_pos >= 1 && row_pos >= 1) begin
                res.mag = sobel_mag(0, 1'b1, col_pos >= 2, row_pos >= 2, row_pos < h);
                have = 1;
            end

            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end

            if (!have) return;
            emitted++;
            res.last = (emitted >= w * h);
            expected_grads.push_back(res);
            if (res.last) restart_frame();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $realtime, msg);
        endtask

        task check_result(logic [MAG_W-1:0] mag, logic last);
            grad_result_t exp_r;
            if (expected_grads.size() == 0) begin
                report_mismatch($sformatf("unexpected result mag=%0d last=%0b", mag, last));
                return;
            end
            exp_r = expected_grads.pop_front();
            if (mag !== exp_r.mag)
                report_mismatch($sformatf("gradient_mag %0d, want %0d", mag, exp_r.mag));
            if (last !== exp_r.last)
                report_mismatch($sformatf("last_of_frame %0b, want %0b", last, exp_r.last));
        endtask

        function int pending();
            return expected_grads.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [7:0]            s_red;
    logic [7:0]            s_green;
    logic [7:0]            s_blue;
    logic                  m_valid;
    logic                  m_ready;
    logic [MAG_W-1:0]      m_gradient_mag;
    logic                  m_last_of_frame;

    gradient_scoreboard sb;

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          hold_requests = 0;
    int unsigned cur_w;
    int unsigned cur_h;
    int          frame_items = 0;

    rgb_sobel_gradient_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gradient_mag  (m_gradient_mag),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Starts and ends at a rising edge; valid stays high after acceptance.
    task automatic send_request(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (src_idle_en && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_red      <= r;
        s_green    <= g;
        s_blue     <= b;
        do @(negedge aclk); while (!s_ready);
        sb.note_request(req, r, g, b);
        @(posedge aclk);
    endtask

    task automatic send_random(logic req);
        send_request(req, rand_channel(), rand_channel(), rand_channel());
    endtask

    task automatic wait_settled();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata);
        int unsigned wm;
        int unsigned hm;
        wait_settled();
        write_reg(REG_FRAME_WIDTH, wdata);
        write_reg(REG_FRAME_HEIGHT, hdata);
        wm = 32'(wdata[FW_W-1:0]);
        hm = 32'(hdata[FH_W-1:0]);
        cur_w = (wm < 1) ? 1 : ((wm > MAX_WIDTH) ? MAX_WIDTH : wm);
        cur_h = (hm < 1) ? 1 : ((hm > MAX_HEIGHT) ? MAX_HEIGHT : hm);
    endtask

    // Full frame: pixels with stray drain ticks, then the flush, sometimes extra drains.
    task automatic run_frame();
        for (int i = 0; i < cur_w * cur_h; i++) begin
            if ($urandom_range(19) == 0) send_random(REQ_DRAIN);
            send_random(REQ_PIXEL);
            frame_items++;
        end
        for (int i = 0; i <= cur_w; i++) begin
            send_random(($urandom_range(3) == 0) ? REQ_PIXEL : REQ_DRAIN);
            frame_items++;
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_random(REQ_DRAIN);
        end
    endtask

    // Broken frame: random mix of requests, left unfinished for the next write.
    task automatic run_partial();
        repeat ($urandom_range(1, cur_w * cur_h + cur_w)) begin
            send_random(($urandom_range(9) < 3) ? REQ_DRAIN : REQ_PIXEL);
            frame_items++;
        end
    endtask

    initial begin
        int          stop_at;
        int unsigned w;
        int unsigned h;
        logic [CFG_DATA_W-1:0] wdata;
        int          phase;

        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_req_type = REQ_PIXEL;
        s_red      = '0;
        s_green    = '0;
        s_blue     = '0;
        sb = new();
        cur_w = FRAME_WIDTH_RST;
        cur_h = FRAME_HEIGHT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset frame size: a short stretch of the first row, no result due yet.
        send_random(REQ_DRAIN);
        repeat (30) send_random(REQ_PIXEL);

        // 3x3 frame with extreme channels, stray drains and pixels past the end.
        set_frame(13'd3, 13'd3);
        send_random(REQ_DRAIN);
        send_request(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        send_request(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        send_request(REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_PIXEL, 8'hFF, 8'h00, 8'h00);
        send_request(REQ_PIXEL, 8'h00, 8'hFF, 8'h00);
        send_request(REQ_PIXEL, 8'h00, 8'h00, 8'hFF);
        send_request(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        send_request(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        repeat (3) send_request(REQ_DRAIN, 8'h00, 8'h00, 8'h00);
        repeat (2) send_request(REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF);

        set_frame(13'd2, 13'd2);
        repeat (4) send_request(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        repeat (3) send_request(REQ_DRAIN, 8'h00, 8'h00, 8'h00);

        // Random frames: mostly small sizes, a few broken ones.
        stop_at = frame_items + RANDOM_ITEMS;
        phase = 0;
        while (frame_items < stop_at) begin
            case ($urandom_range(9))
                0:       w = 1;
                1:       w = 2;
                8:       w = 0;
                9:       w = $urandom_range(9, 20);
                default: w = $urandom_range(3, 8);
            endcase
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            if (phase == 0) begin
                w = 4;
                h = 8;
            end else if (phase == 1) begin
                w = 8;
                h = 8;
            end
            wdata = CFG_DATA_W'(w);
            // Upper data bits are beyond the width register and must be dropped.
            if ($urandom_range(4) == 0)
                wdata[CFG_DATA_W-1:FW_W] = (CFG_DATA_W-FW_W)'($urandom_range(1, 3));
            set_frame(wdata, CFG_DATA_W'(h));
            if (phase == 0) begin
                // Stall the result side while frames keep arriving.
                hold_requests++;
                repeat (3) run_frame();
            end else if (phase == 1) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
                repeat (2) run_frame();
                src_idle_en  = 1'b1;
                sink_idle_en = 1'b1;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(9) == 0) run_partial();
                    else run_frame();
                end
            end
            phase++;
        end

        // Narrowest row, clamped from zero, with the tallest frame, left unfinished.
        set_frame(13'd0, 13'h1FFF);
        repeat (40) send_random(REQ_PIXEL);
        // Widest row, clamped from all ones, with a zero height, left unfinished.
        set_frame(13'h1FFF, 13'd0);
        repeat (40) send_random(REQ_PIXEL);

        s_valid <= 1'b0;
        for (int i = 0; i < 20000 && sb.pending() != 0; i++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: random back-pressure plus an occasional long hold-off.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= !(sink_idle_en && $urandom_range(99) < 26);
            end
            @(negedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_gradient_mag, m_last_of_frame);
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
